@@ hdl/serial_deviation_frame_parser_macros.svh @@
// Assertion macros used by the serial deviation frame parser RTL.
`ifndef SERIAL_DEVIATION_FRAME_PARSER_MACROS_SVH
`define SERIAL_DEVIATION_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SDFP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SDFP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sdfp_pkg.sv @@
// Types and constants of the serial deviation frame parser.
package sdfp_pkg;

   localparam int FRAME_MAX   = 20;
   localparam int PAYLOAD_MAX = 4;

   localparam logic [7:0] HEADER_RESET = 8'h57;  // 'W'
   localparam logic [7:0] TAIL_RESET   = 8'h58;  // 'X'

   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_POINT = 8'h2E;

   localparam logic [2:0] CSR_ADDR_HEADER = 3'd0;
   localparam logic [2:0] CSR_ADDR_TAIL   = 3'd4;

   typedef enum logic [2:0] {
      KIND_X_UPDATE = 3'd0,
      KIND_Y_UPDATE = 3'd1,
      KIND_SCAN_ON  = 3'd2,
      KIND_SCAN_OFF = 3'd3,
      KIND_UNKNOWN  = 3'd4,
      KIND_EMPTY    = 3'd5
   } frame_kind_type;

   typedef struct packed {
      logic [7:0] header_char;
      logic [7:0] tail_char;
   } csr_cfg_type;

   typedef struct packed {
      frame_kind_type     frame_kind;
      logic signed [20:0] x_dev_hundredths;
      logic signed [20:0] y_dev_hundredths;
      logic               scan_on;
   } result_type;

endpackage

@@ hdl/sdfp_csr.sv @@
// Configuration registers: header and tail bytes behind an APB-style port.
module sdfp_csr
   import sdfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output csr_cfg_type cfg
);

   logic [7:0] header_ff, header_in;
   logic [7:0] tail_ff, tail_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // byte lanes within a word are ignored
   always_comb begin
      header_in = header_ff;
      tail_in   = tail_ff;
      if (wr_en) begin
         case ({csr_paddr[2], 2'b00})
            CSR_ADDR_HEADER: header_in = csr_pwdata[7:0];
            CSR_ADDR_TAIL:   tail_in   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         tail_ff   <= TAIL_RESET;
      end else begin
         header_ff <= header_in;
         tail_ff   <= tail_in;
      end
   end

   always_comb begin
      case ({csr_paddr[2], 2'b00})
         CSR_ADDR_HEADER: csr_prdata = {24'd0, header_ff};
         CSR_ADDR_TAIL:   csr_prdata = {24'd0, tail_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg.header_char = header_ff;
   assign cfg.tail_char   = tail_ff;

endmodule

@@ hdl/sdfp_parser.sv @@
// Frame and payload parser: frame state, decimal accumulation, deviations.
`include "serial_deviation_frame_parser_macros.svh"

module sdfp_parser
   import sdfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  csr_cfg_type cfg,
   input  logic        step_en,
   input  logic [7:0]  rx_byte,
   output logic        res_valid,
   output result_type  res
);

   logic [4:0]         frame_count_ff, frame_count_in;
   logic [7:0]         command_ff, command_in;
   logic [2:0]         payload_count_ff, payload_count_in;
   logic [13:0]        int_acc_ff, int_acc_in;
   logic [6:0]         frac_acc_ff, frac_acc_in;
   logic [1:0]         frac_digits_ff, frac_digits_in;
   logic               point_seen_ff, point_seen_in;
   logic               stopped_ff, stopped_in;
   logic signed [20:0] x_dev_ff, x_dev_in;
   logic signed [20:0] y_dev_ff, y_dev_in;
   logic               scan_ff, scan_in;

   logic [4:0]  frame_count_inc;
   logic [3:0]  digit;
   logic [6:0]  frac_eff;
   logic [20:0] value;
   logic        is_digit;

   assign digit    = 4'(rx_byte - CHAR_ZERO);
   assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign frame_count_inc = frame_count_ff + 5'd1;

   // payload in hundredths; only two fraction digits are kept
   always_comb begin
      case (frac_digits_ff)
         2'd0:    frac_eff = 7'd0;
         2'd1:    frac_eff = 7'(frac_acc_ff * 7'd10);
         default: frac_eff = frac_acc_ff;
      endcase
      value = 21'(21'(int_acc_ff) * 21'd100) + 21'(frac_eff);
   end

   always_comb begin
      frame_count_in   = frame_count_ff;
      command_in       = command_ff;
      payload_count_in = payload_count_ff;
      int_acc_in       = int_acc_ff;
      frac_acc_in      = frac_acc_ff;
      frac_digits_in   = frac_digits_ff;
      point_seen_in    = point_seen_ff;
      stopped_in       = stopped_ff;
      x_dev_in         = x_dev_ff;
      y_dev_in         = y_dev_ff;
      scan_in          = scan_ff;
      res_valid        = 1'b0;
      res.frame_kind   = KIND_EMPTY;

      if (frame_count_ff == 5'd0) begin
         // resync: only the header opens a frame, and never closes it
         if (rx_byte == cfg.header_char) frame_count_in = 5'd1;
      end else if (rx_byte != cfg.tail_char) begin
         if (frame_count_ff == 5'd1) begin
            command_in = rx_byte;
         end else if (payload_count_ff < 3'(PAYLOAD_MAX)) begin
            payload_count_in = payload_count_ff + 3'd1;
            if (!stopped_ff) begin
               if (is_digit) begin
                  if (!point_seen_ff) begin
                     int_acc_in = 14'(18'(int_acc_ff) * 18'd10 + 18'(digit));
                  end else if (frac_digits_ff < 2'd2) begin
                     frac_acc_in    = 7'(11'(frac_acc_ff) * 11'd10 + 11'(digit));
                     frac_digits_in = frac_digits_ff + 2'd1;
                  end
               end else if (rx_byte == CHAR_POINT && !point_seen_ff) begin
                  point_seen_in = 1'b1;
               end else begin
                  stopped_in = 1'b1;
               end
            end
         end
         frame_count_in = frame_count_inc;
         // overlong frame is dropped without a result
         if (frame_count_inc >= 5'(FRAME_MAX)) begin
            frame_count_in   = 5'd0;
            command_in       = 8'd0;
            payload_count_in = 3'd0;
            int_acc_in       = 14'd0;
            frac_acc_in      = 7'd0;
            frac_digits_in   = 2'd0;
            point_seen_in    = 1'b0;
            stopped_in       = 1'b0;
         end
      end else begin
         res_valid = 1'b1;
         if (frame_count_ff == 5'd1) begin
            res.frame_kind = KIND_EMPTY;
         end else begin
            case (command_ff)
               CHAR_A: begin
                  x_dev_in = value;
                  res.frame_kind = KIND_X_UPDATE;
               end
               CHAR_B: begin
                  x_dev_in = 21'(~value + 21'd1);
                  res.frame_kind = KIND_X_UPDATE;
               end
               CHAR_C: begin
                  y_dev_in = value;
                  res.frame_kind = KIND_Y_UPDATE;
               end
               CHAR_D: begin
                  y_dev_in = 21'(~value + 21'd1);
                  res.frame_kind = KIND_Y_UPDATE;
               end
               CHAR_S: begin
                  scan_in = 1'b1;
                  res.frame_kind = KIND_SCAN_ON;
               end
               CHAR_F: begin
                  scan_in = 1'b0;
                  res.frame_kind = KIND_SCAN_OFF;
               end
               default: res.frame_kind = KIND_UNKNOWN;
            endcase
         end
         frame_count_in   = 5'd0;
         command_in       = 8'd0;
         payload_count_in = 3'd0;
         int_acc_in       = 14'd0;
         frac_acc_in      = 7'd0;
         frac_digits_in   = 2'd0;
         point_seen_in    = 1'b0;
         stopped_in       = 1'b0;
      end

      res.x_dev_hundredths = x_dev_in;
      res.y_dev_hundredths = y_dev_in;
      res.scan_on          = scan_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff   <= 5'd0;
         command_ff       <= 8'd0;
         payload_count_ff <= 3'd0;
         int_acc_ff       <= 14'd0;
         frac_acc_ff      <= 7'd0;
         frac_digits_ff   <= 2'd0;
         point_seen_ff    <= 1'b0;
         stopped_ff       <= 1'b0;
         x_dev_ff         <= 21'sd0;
         y_dev_ff         <= 21'sd0;
         scan_ff          <= 1'b0;
      end else if (step_en) begin
         frame_count_ff   <= frame_count_in;
         command_ff       <= command_in;
         payload_count_ff <= payload_count_in;
         int_acc_ff       <= int_acc_in;
         frac_acc_ff      <= frac_acc_in;
         frac_digits_ff   <= frac_digits_in;
         point_seen_ff    <= point_seen_in;
         stopped_ff       <= stopped_in;
         x_dev_ff         <= x_dev_in;
         y_dev_ff         <= y_dev_in;
         scan_ff          <= scan_in;
      end
   end

   `SDFP_ASSERT_IMP(a_frame_bound, 1'b1, frame_count_ff < 5'(FRAME_MAX), "frame count overrun")
   `SDFP_ASSERT_IMP(a_payload_bound, 1'b1, payload_count_ff <= 3'(PAYLOAD_MAX), "payload overrun")
   `SDFP_ASSERT_IMP(a_frac_bound, 1'b1, frac_digits_ff <= 2'd2, "too many fraction digits")
   `SDFP_ASSERT_NXT(a_result_clears, step_en && res_valid, frame_count_ff == 5'd0,
                    "frame not cleared after result")

endmodule

@@ hdl/serial_deviation_frame_parser.sv @@
// Serial deviation frame parser: one received byte per cycle is accepted
// into an input register, parsed in a single pass and, when it closes a
// frame, the result item lands in the output register when the byte leaves
// the input register. The sustained rate is one byte per clock; the only stall
// comes from a closing byte whose result meets a full output register that
// the consumer is not draining. Configuration is written over the APB port.

module serial_deviation_frame_parser
   import sdfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [20:0] x_dev_hundredths, [41:21] y_dev_hundredths,
                                    // [42] scan_on, [47:43] zero
   output logic [2:0]  rsp_tuser    // [2:0] frame_kind
);

   csr_cfg_type cfg;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   logic        res_valid;
   result_type  res;
   logic        out_free;
   logic        advance;

   sdfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step_en   (advance),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   // bytes that give no result pass even while the output is full
   assign advance    = in_valid_ff && (!res_valid || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end
      if (rsp_tready) out_valid_in = 1'b0;
      if (advance && res_valid) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.frame_kind;
   assign rsp_tdata  = {5'd0, out_ff.scan_on, out_ff.y_dev_hundredths,
                        out_ff.x_dev_hundredths};

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the serial deviation frame parser.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sdfp_pkg::*;

   localparam int         STALL_LIMIT  = 4000;  // cycles without any handshake
   localparam int         DRAIN_CYCLES = 8;
   localparam int         HOLD_CYCLES  = 400;
   localparam logic [7:0] CHAR_ODD_CMD = 8'h5A;  // 'Z', not a known command
   localparam logic [7:0] CHAR_EXP     = 8'h65;  // 'e'
   localparam logic [7:0] CHAR_HEX_X   = 8'h78;  // 'x'

   logic        clock;
   logic        reset;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;          // [20:0] x, [41:21] y, [42] scan_on
   logic [2:0]  rsp_tuser;          // [2:0] frame_kind

   serial_deviation_frame_parser dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // Parser state as predicted from the bytes accepted so far
   logic [7:0]         header_shadow = HEADER_RESET;
   logic [7:0]         tail_shadow   = TAIL_RESET;
   logic [4:0]         frame_len     = '0;
   logic [7:0]         cmd_letter    = '0;
   logic [2:0]         chars_taken   = '0;
   logic [13:0]        int_part      = '0;
   logic [6:0]         frac_part     = '0;
   logic [1:0]         frac_len      = '0;
   logic               point_found   = 1'b0;
   logic               parse_halted  = 1'b0;
   logic signed [20:0] x_hundredths  = '0;
   logic signed [20:0] y_hundredths  = '0;
   logic               scanning      = 1'b0;

   result_type pending_results[$];
   int         mismatch_count = 0;
   int         bytes_sent     = 0;
   bit         tx_idle_on     = 1'b1;
   bit         rx_idle_on     = 1'b1;
   int         hold_off_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%t mismatch: %s", $realtime, msg);
   endfunction

   function automatic void clear_frame_state();
      frame_len    = '0;
      cmd_letter   = '0;
      chars_taken  = '0;
      int_part     = '0;
      frac_part    = '0;
      frac_len     = '0;
      point_found  = 1'b0;
      parse_halted = 1'b0;
   endfunction

   // Advance the predicted parser by one byte; a closing tail queues a result.
   function automatic void parse_byte(input logic [7:0] c);
      result_type  res;
      int          value;
      int          frac;
      if (frame_len == 0) begin
         if (c == header_shadow)
            frame_len = 5'd1;
         return;
      end
      if (c != tail_shadow) begin
         if (frame_len == 1)
            cmd_letter = c;
         else if (chars_taken < PAYLOAD_MAX) begin
            chars_taken++;
            if (!parse_halted) begin
               if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                  if (!point_found)
                     int_part = int_part * 14'd10 + 14'(c - CHAR_ZERO);
                  else if (frac_len < 2) begin
                     frac_part = frac_part * 7'd10 + 7'(c - CHAR_ZERO);
                     frac_len++;
                  end
               end else if (c == CHAR_POINT && !point_found)
                  point_found = 1'b1;
               else
                  parse_halted = 1'b1;
            end
         end
         frame_len++;
         if (frame_len >= FRAME_MAX)
            clear_frame_state();
         return;
      end
      if (frame_len == 1)
         res.frame_kind = KIND_EMPTY;
      else begin
         frac  = (frac_len == 0) ? 0 : (frac_len == 1) ? int'(frac_part) * 10 : int'(frac_part);
         value = int'(int_part) * 100 + frac;
         case (cmd_letter)
            CHAR_A: begin x_hundredths = 21'(value);  res.frame_kind = KIND_X_UPDATE; end
            CHAR_B: begin x_hundredths = 21'(-value); res.frame_kind = KIND_X_UPDATE; end
            CHAR_C: begin y_hundredths = 21'(value);  res.frame_kind = KIND_Y_UPDATE; end
            CHAR_D: begin y_hundredths = 21'(-value); res.frame_kind = KIND_Y_UPDATE; end
            CHAR_S: begin scanning = 1'b1; res.frame_kind = KIND_SCAN_ON; end
            CHAR_F: begin scanning = 1'b0; res.frame_kind = KIND_SCAN_OFF; end
            default: res.frame_kind = KIND_UNKNOWN;
         endcase
      end
      clear_frame_state();
      res.x_dev_hundredths = x_hundredths;
      res.y_dev_hundredths = y_hundredths;
      res.scan_on          = scanning;
      pending_results.push_back(res);
   endfunction

   // Input acceptance is handled before the output check so that even a
   // same-edge result would find its expectation queued.
   always @(posedge clock) begin
      result_type exp_res;
      if (!reset) begin
         if (req_tvalid && req_tready)
            parse_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0)
               flag_error($sformatf("unexpected result kind %0d x %0d y %0d scan %0b",
                  rsp_tuser, $signed(rsp_tdata[20:0]), $signed(rsp_tdata[41:21]),
                  rsp_tdata[42]));
            else begin
               exp_res = pending_results.pop_front();
               if (rsp_tuser !== exp_res.frame_kind
                     || rsp_tdata[20:0] !== exp_res.x_dev_hundredths
                     || rsp_tdata[41:21] !== exp_res.y_dev_hundredths
                     || rsp_tdata[42] !== exp_res.scan_on)
                  flag_error($sformatf(
                     "kind %0d/%0d x %0d/%0d y %0d/%0d scan %0b/%0b (expected/actual)",
                     exp_res.frame_kind, rsp_tuser,
                     exp_res.x_dev_hundredths, $signed(rsp_tdata[20:0]),
                     exp_res.y_dev_hundredths, $signed(rsp_tdata[41:21]),
                     exp_res.scan_on, rsp_tdata[42]));
            end
         end
      end
   end

   function automatic int next_gap(input bit enabled);
      int roll;
      if (!enabled)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   // Result sink: random stalls, plus a long hold-off on request
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
            rsp_tready <= 1'b1;
         end else begin
            stall = next_gap(rx_idle_on);
            if (stall == 0)
               rsp_tready <= 1'b1;
            else begin
               rsp_tready <= 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   // Watchdog: ends the run once nothing has moved for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
               || (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("[serial_deviation_frame_parser] ERROR");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      gap = next_gap(tx_idle_on);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_frame(input logic [7:0] cmd, input string payload);
      send_byte(header_shadow);
      send_byte(cmd);
      for (int i = 0; i < payload.len(); i++)
         send_byte(payload[i]);
      send_byte(tail_shadow);
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_framing(input logic [7:0] hdr, input logic [7:0] tl);
      logic [31:0] readback;
      wait_for_idle();
      csr_access(1'b1, CSR_ADDR_HEADER, {24'd0, hdr}, readback);
      header_shadow = hdr;
      csr_access(1'b1, CSR_ADDR_TAIL, {24'd0, tl}, readback);
      tail_shadow = tl;
      csr_access(1'b0, CSR_ADDR_HEADER, '0, readback);
      if (readback !== {24'd0, hdr})
         flag_error($sformatf("header_char read %0h, expected %0h", readback, hdr));
      csr_access(1'b0, CSR_ADDR_TAIL, '0, readback);
      if (readback !== {24'd0, tl})
         flag_error($sformatf("tail_char read %0h, expected %0h", readback, tl));
   endtask

   function automatic logic [7:0] random_command();
      logic [7:0] known[6] = '{CHAR_A, CHAR_B, CHAR_C, CHAR_D, CHAR_S, CHAR_F};
      if ($urandom_range(0, 99) < 85)
         return known[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] random_payload_char();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 62)
         return CHAR_ZERO + 8'($urandom_range(0, 9));
      if (roll < 76)
         return CHAR_POINT;
      if (roll < 82)
         return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_random_frame();
      int shape;
      shape = $urandom_range(0, 99);
      if (shape < 82) begin
         send_byte(header_shadow);
         send_byte(random_command());
         repeat ($urandom_range(0, 6)) send_byte(random_payload_char());
         send_byte(tail_shadow);
      end else if (shape < 90)
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      else if (shape < 95) begin
         // around the frame limit: from 18 digits on, the limit is hit before the tail
         send_byte(header_shadow);
         send_byte(random_command());
         repeat ($urandom_range(FRAME_MAX - 3, FRAME_MAX + 4))
            send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
         send_byte(tail_shadow);
      end else begin
         // no tail: the next frame's bytes land in this payload
         send_byte(header_shadow);
         send_byte(random_command());
         repeat ($urandom_range(0, 3)) send_byte(random_payload_char());
      end
   endtask

   task automatic test_commands();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(CHAR_A, "12.5");
      send_frame(CHAR_B, "9999");
      send_frame(CHAR_C, ".999");
      send_frame(CHAR_D, "0.01");
      send_frame(CHAR_S, "");
      send_frame(CHAR_F, "3");
      send_frame(CHAR_ODD_CMD, "7");
      send_byte(header_shadow);
      send_byte(tail_shadow);
      wait_for_idle();
   endtask

   task automatic test_special_cases();
      send_frame(CHAR_A, {"1", string'(header_shadow), "2"});
      send_frame(CHAR_C, "123456");
      send_frame(CHAR_A, "");
      send_frame(CHAR_B, {string'(CHAR_MINUS), "5"});
      send_frame(CHAR_D, {string'(CHAR_PLUS), "5"});
      send_frame(CHAR_A, {"1", string'(CHAR_EXP), "2"});
      send_frame(CHAR_C, {"0", string'(CHAR_HEX_X), "1F"});
      send_frame(CHAR_B, "1.2.3");
      // overlong frame: dropped, and its remaining digits are ignored as junk
      send_byte(header_shadow);
      send_byte(CHAR_A);
      repeat (FRAME_MAX) send_byte(CHAR_NINE);
      send_frame(CHAR_S, "");
      wait_for_idle();
   endtask

   task automatic test_framing_registers();
      set_framing(8'h7E, 8'h7E);
      // header equal to tail: the opener never closes, the next one does
      send_byte(8'h7E);
      send_byte(8'h7E);
      send_frame(CHAR_C, "42");
      set_framing(8'h00, 8'hFF);
      send_frame(CHAR_D, "8.8");
      set_framing(8'hFF, 8'h00);
      send_frame(CHAR_A, "0.5");
      wait_for_idle();
   endtask

   task automatic test_output_backpressure();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      hold_off_cycles = HOLD_CYCLES;
      for (int i = 0; i < 40; i++)
         send_frame(i[0] ? CHAR_S : CHAR_F, "");
      wait_for_idle();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic(input int byte_budget);
      int stop_at;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         // switch between idling and back-to-back stretches now and then
         if ($urandom_range(0, 9) == 0) begin
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);
         end
         send_random_frame();
      end
      wait_for_idle();
   endtask

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_commands();
      test_special_cases();
      test_framing_registers();
      test_output_backpressure();
      set_framing(HEADER_RESET, TAIL_RESET);
      test_random_traffic(400);
      set_framing(8'h00, 8'hFF);
      test_random_traffic(200);
      set_framing(8'hFF, 8'h00);
      test_random_traffic(200);
      set_framing(8'h7E, 8'h7E);
      test_random_traffic(100);
      set_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      test_random_traffic(100);

      wait_for_idle();
      if (pending_results.size() != 0)
         flag_error($sformatf("%0d results never arrived", pending_results.size()));
      if (mismatch_count == 0)
         $display("[serial_deviation_frame_parser] OK");
      else
         $display("[serial_deviation_frame_parser] ERROR");
      $finish;
   end

endmodule
